/* sv/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, constants and curve tables of the bump map shader.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int GRAD_W     = 11;

    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 24;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] ROW_FULL = 2'd2;

    localparam logic [63:0] PI_FIX = 64'h3243F6A8885A308D;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_X      = 3'd0,
        REG_LIGHT_Y      = 3'd1,
        REG_LIGHT_Z      = 3'd2,
        REG_NORMAL_Z     = 3'd3,
        REG_COMPENSATION = 3'd4,
        REG_AMBIENT      = 3'd5,
        REG_HEIGHT_CURVE = 3'd6,
        REG_COMPENSATE   = 3'd7
    } t_reg_idx;

    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_SPHERE = 2'd1;
    localparam logic [1:0] CURVE_SINE   = 2'd2;

    typedef struct packed {
        logic [8:0]  light_x;
        logic [8:0]  light_y;
        logic [7:0]  light_z;
        logic [10:0] normal_z;
        logic [16:0] compensation;
        logic [7:0]  ambient;
        logic [2:0]  height_curve;
        logic        compensate;
    } t_cfg;

    typedef struct packed {
        logic [GRAD_W-1:0] nx;
        logic [GRAD_W-1:0] ny;
        logic              row_end;
    } t_grad;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    typedef logic [7:0] t_curve [256];

    // floor(a*b / 2^60), low 64 bits
    function automatic logic [63:0] mul_fix(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_curve build_sphere();
        t_curve      t;
        logic [63:0] v;
        logic [63:0] r;
        for (int i = 0; i < 256; i++) begin
            v = 64'(i) * 64'(510 - i);
            r = isqrt_c(v);
            if (v > r * r + r) r = r + 64'd1;
            t[i] = (r > 64'd255) ? 8'hFF : r[7:0];
        end
        return t;
    endfunction

    // sin^2 by an eleven-term series in 4.60 fixed point
    function automatic t_curve build_sine();
        t_curve      t;
        logic [63:0] step;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] q;
        step = PI_FIX / 64'd510;
        for (int i = 0; i < 256; i++) begin
            y    = step * 64'(i);
            y2   = mul_fix(y, y);
            term = y;
            pos  = y;
            neg  = '0;
            for (int k = 1; k <= 10; k++) begin
                term = mul_fix(term, y2) / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) == 1) neg = neg + term;
                else pos = pos + term;
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            q = mul_fix(s, s) >> 28;
            q = (64'd255 * q + (64'd1 << 31)) >> 32;
            t[i] = (q > 64'd255) ? 8'hFF : q[7:0];
        end
        return t;
    endfunction

    localparam t_curve SPHERE_TAB = build_sphere();
    localparam t_curve SINE_TAB   = build_sine();

endpackage

`default_nettype wire

/* sv/bms_ram.sv */
// ----------------------------------------------------------------------------
// bms_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/bms_fifo.sv */
// ----------------------------------------------------------------------------
// bms_fifo
// Short gradient queue between the window front end and the shading back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bms_pkg::t_grad i_data,
    input  wire logic          i_pop,
    output bms_pkg::t_grad     o_head,
    output logic               o_nonempty,
    output logic               o_room
);
    import bms_pkg::*;

    t_grad                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop) r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = (r_count != '0);
    // one slot kept for the word still in the front end
    assign o_room     = (r_count < FIFO_CNT_W'(FIFO_DEPTH - 1));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FIFO_CNT_W'(FIFO_DEPTH)) || i_pop)
        else $error("gradient queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("gradient queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("gradient queue count mismatch");

endmodule

`default_nettype wire

/* sv/bms_front.sv */
// ----------------------------------------------------------------------------
// bms_front
// Height curve lookup, line stores, 3x3 window and gradient calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bms_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_height,
    input  wire logic          i_row_end,
    input  wire logic          i_frame_start,
    input  wire logic          i_room,
    output logic               o_push,
    output bms_pkg::t_grad     o_grad
);
    import bms_pkg::*;

    logic             accept;
    logic [7:0]       curved;
    logic [7:0]       mapped;
    logic [COL_W-1:0] col_eff;
    logic [1:0]       row_eff;
    logic [COL_W-1:0] n_col;
    logic [1:0]       n_row;
    logic             in_range;
    logic             produce;

    logic [COL_W-1:0]  r_col;
    logic [1:0]        r_row;
    logic              r_s2_valid;
    logic              r_s2_store;
    logic              r_s2_produce;
    logic              r_s2_row_end;
    logic [7:0]        r_s2_h;
    logic [ADDR_W-1:0] r_s2_addr;
    logic              r_s2_byp;
    logic [7:0]        r_s2_byp_up;
    logic [7:0]        r_s2_byp_mid;
    logic [7:0]        r_win [6];

    logic [7:0] up_q;
    logic [7:0] mid_q;
    logic [7:0] up;
    logic [7:0] mid;
    logic       wr_en;
    logic [9:0] s_left;
    logic [9:0] s_right;
    logic [9:0] s_bot;
    logic [9:0] s_top;
    logic [11:0] nx_w;
    logic [11:0] ny_w;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    always_comb begin
        case (i_cfg.height_curve[2:1])
            CURVE_SPHERE: curved = SPHERE_TAB[i_height];
            CURVE_SINE:   curved = SINE_TAB[i_height];
            default:      curved = i_height;
        endcase
        mapped = i_cfg.height_curve[0] ? ~curved : curved;
    end

    always_comb begin
        col_eff  = i_frame_start ? '0 : r_col;
        row_eff  = i_frame_start ? '0 : r_row;
        in_range = (col_eff < COL_W'(MAX_WIDTH));
        produce  = (row_eff == ROW_FULL) && (col_eff >= COL_W'(2)) && in_range;
        if (i_row_end) begin
            n_col = '0;
            n_row = (row_eff < ROW_FULL) ? row_eff + 2'd1 : row_eff;
        end else begin
            n_row = row_eff;
            n_col = in_range ? col_eff + 1'b1 : col_eff;
        end
    end

    bms_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s2_addr),
        .i_wdata (mid),
        .i_raddr (col_eff[ADDR_W-1:0]),
        .o_rdata (up_q)
    );

    bms_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s2_addr),
        .i_wdata (r_s2_h),
        .i_raddr (col_eff[ADDR_W-1:0]),
        .o_rdata (mid_q)
    );

    // a same-column write in flight wins over the ram read
    assign up    = r_s2_byp ? r_s2_byp_up : up_q;
    assign mid   = r_s2_byp ? r_s2_byp_mid : mid_q;
    assign wr_en = r_s2_valid && r_s2_store;

    always_comb begin
        s_left  = {2'b0, r_win[0]} + {2'b0, r_win[1]} + {2'b0, r_win[2]};
        s_right = {2'b0, up} + {2'b0, mid} + {2'b0, r_s2_h};
        s_bot   = {2'b0, r_win[2]} + {2'b0, r_win[5]} + {2'b0, r_s2_h};
        s_top   = {2'b0, r_win[0]} + {2'b0, r_win[3]} + {2'b0, up};
        nx_w    = {2'b0, s_left} - {2'b0, s_right};
        ny_w    = {2'b0, s_bot} - {2'b0, s_top};
    end

    assign o_push         = r_s2_valid && r_s2_produce;
    assign o_grad.nx      = nx_w[GRAD_W-1:0];
    assign o_grad.ny      = ny_w[GRAD_W-1:0];
    assign o_grad.row_end = r_s2_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s2_valid <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            r_s2_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (wr_en) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= up;
                r_win[4] <= mid;
                r_win[5] <= r_s2_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_store   <= in_range;
            r_s2_produce <= produce;
            r_s2_row_end <= i_row_end;
            r_s2_h       <= mapped;
            r_s2_addr    <= col_eff[ADDR_W-1:0];
            r_s2_byp     <= wr_en && (r_s2_addr == col_eff[ADDR_W-1:0]);
            r_s2_byp_up  <= mid;
            r_s2_byp_mid <= r_s2_h;
        end
    end

endmodule

`default_nettype wire

/* sv/bms_div.sv */
// ----------------------------------------------------------------------------
// bms_div
// Shared restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bms_pkg::t_div_req i_req,
    output bms_pkg::t_div_rsp      o_rsp
);
    import bms_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

/* sv/bms_back.sv */
// ----------------------------------------------------------------------------
// bms_back
// Shading sequencer: light dot product, normal length, ambient fill and
// compensation, with a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bms_pkg::t_cfg     i_cfg,
    input  wire logic              i_grad_valid,
    input  wire bms_pkg::t_grad    i_grad,
    output logic                   o_pop,
    output bms_pkg::t_div_req      o_div_req,
    input  wire bms_pkg::t_div_rsp i_div_rsp,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_shade,
    output logic                   o_last
);
    import bms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DOT,
        S_DIV_Q,
        S_SQRT,
        S_AMB1,
        S_AMB2,
        S_AMB3,
        S_COMP,
        S_CDIV,
        S_OUT
    } t_state;

    // ceil(2^25 / 255): floor(x / 255) = (x * AMB_RECIP) >> 25 for x below 2^17
    localparam logic [17:0] AMB_RECIP = 18'd131587;

    t_state               r_state;
    logic [GRAD_W-1:0]    r_nx;
    logic [GRAD_W-1:0]    r_ny;
    logic                 r_last;
    logic signed [19:0]   r_p1;
    logic signed [19:0]   r_p2;
    logic [18:0]          r_p3;
    logic signed [21:0]   r_dot;
    logic [22:0]          r_d;
    logic [DIV_NUM_W-1:0] r_sv;
    logic [DIV_NUM_W-1:0] r_sr;
    logic [DIV_NUM_W-1:0] r_sbit;
    logic [4:0]           r_scnt;
    logic [32:0]          r_na;
    logic [34:0]          r_amb_p;
    logic [20:0]          r_sh;
    logic [7:0]           r_res;
    logic                 r_div_start;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;
    logic                 r_out_valid;
    logic [7:0]           r_shade;
    logic                 r_out_last;

    logic signed [21:0] nx_sq;
    logic signed [21:0] ny_sq;
    logic [21:0]        nz_sq;
    logic [24:0]        ca;
    logic [24:0]        c255;
    logic [35:0]        qsh;
    logic [35:0]        num_diff;
    logic               num_pos;
    logic [DIV_NUM_W:0] s_sum;
    logic               s_ge;
    logic [9:0]         shc;
    logic [7:0]         sh_sat;

    always_comb begin
        nx_sq    = $signed(r_nx) * $signed(r_nx);
        ny_sq    = $signed(r_ny) * $signed(r_ny);
        nz_sq    = i_cfg.normal_z * i_cfg.normal_z;
        ca       = i_cfg.compensation * i_cfg.ambient;
        c255     = {i_cfg.compensation, 8'b0} - {8'b0, i_cfg.compensation};
        qsh      = {r_sr[19:0], 16'b0};
        num_pos  = ({11'b0, c255} > qsh);
        num_diff = {11'b0, c255} - qsh;
        s_sum    = {1'b0, r_sr} + {1'b0, r_sbit};
        s_ge     = ({1'b0, r_sv} >= s_sum);
        shc      = (r_sh > 21'd511) ? 10'd512 : r_sh[9:0];
        sh_sat   = (r_sh > 21'd255) ? 8'hFF : r_sh[7:0];
    end

    assign o_pop = (r_state == S_IDLE) && i_grad_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_grad_valid) begin
                        r_nx   <= i_grad.nx;
                        r_ny   <= i_grad.ny;
                        r_last <= i_grad.row_end;
                        if (i_grad.nx == '0 && i_grad.ny == '0) begin
                            r_sh    <= {13'b0, i_cfg.light_z};
                            r_state <= S_COMP;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_p1    <= $signed(r_nx) * $signed(i_cfg.light_x);
                    r_p2    <= $signed(r_ny) * $signed(i_cfg.light_y);
                    r_p3    <= i_cfg.normal_z * i_cfg.light_z;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_dot   <= $signed({{2{r_p1[19]}}, r_p1})
                             + $signed({{2{r_p2[19]}}, r_p2})
                             + $signed({3'b0, r_p3});
                    r_d     <= {3'b0, nx_sq[19:0]} + {3'b0, ny_sq[19:0]} + {1'b0, nz_sq};
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    if (r_dot[21]) begin
                        r_sh    <= {12'b0, ca[24:16]};
                        r_state <= S_COMP;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_dot[19:0] * r_dot[19:0];
                        r_div_den   <= {1'b0, r_d};
                        r_state     <= S_DIV_Q;
                    end
                end
                S_DIV_Q: begin
                    if (i_div_rsp.done) begin
                        r_sv    <= i_div_rsp.quo;
                        r_sr    <= '0;
                        r_sbit  <= DIV_NUM_W'(1) << (DIV_NUM_W - 2);
                        r_scnt  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // one result bit per step
                    if (s_ge) begin
                        r_sv <= r_sv - s_sum[DIV_NUM_W-1:0];
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == 5'(DIV_NUM_W / 2 - 1)) r_state <= S_AMB1;
                end
                S_AMB1: begin
                    if (num_pos) begin
                        r_na    <= num_diff[24:0] * i_cfg.ambient;
                        r_state <= S_AMB2;
                    end else begin
                        r_sh    <= {1'b0, r_sr[19:0]};
                        r_state <= S_COMP;
                    end
                end
                S_AMB2: begin
                    r_amb_p <= r_na[32:16] * AMB_RECIP;
                    r_state <= S_AMB3;
                end
                S_AMB3: begin
                    r_sh    <= {1'b0, r_sr[19:0]} + {11'b0, r_amb_p[34:25]};
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (i_cfg.compensate) begin
                        if (i_cfg.compensation == '0) begin
                            r_res   <= 8'hFF;
                            r_state <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_div_num   <= {14'b0, shc, 16'b0};
                            r_div_den   <= {7'b0, i_cfg.compensation};
                            r_state     <= S_CDIV;
                        end
                    end else begin
                        r_res   <= sh_sat;
                        r_state <= S_OUT;
                    end
                end
                S_CDIV: begin
                    if (i_div_rsp.done) begin
                        r_res   <= (i_div_rsp.quo > DIV_NUM_W'(255)) ? 8'hFF
                                                                     : i_div_rsp.quo[7:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_shade     <= r_res;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_div_req.start = r_div_start;
    assign o_div_req.num   = r_div_num;
    assign o_div_req.den   = r_div_den;
    assign o_valid         = r_out_valid;
    assign o_shade         = r_shade;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

/* sv/bump_map_shader_top.sv */
// ----------------------------------------------------------------------------
// bump_map_shader_top
// Emboss shading of an 8-bit height stream over a 3x3 window.
// ----------------------------------------------------------------------------
// The front end takes one height word per clock while the gradient queue has
// room; border pixels (first two rows and columns) give no result. Each
// interior pixel is shaded by a sequencer in the back end, which pops the
// next gradient only once the last one is done. Flat and back-lit pixels
// skip the first division and the square root; compensation can add another
// pass through the 40-step serial divider (used up to twice per pixel); the
// square root has 20 steps. Line stores come up unwritten, so the first
// frame must not have a row longer than the rows before it.
`default_nettype none

module bump_map_shader_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // height
    input  wire logic                               s_axis_tlast,
    input  wire logic                               s_axis_tuser,  // frame_start
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,  // shade
    output logic                                    m_axis_tlast
);
    import bms_pkg::*;

    t_cfg     r_cfg;
    t_grad    push_grad;
    t_grad    head_grad;
    logic     push;
    logic     pop;
    logic     nonempty;
    logic     room;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x      <= '0;
            r_cfg.light_y      <= '0;
            r_cfg.light_z      <= 8'd255;
            r_cfg.normal_z     <= 11'd1530;
            r_cfg.compensation <= 17'd65536;
            r_cfg.ambient      <= '0;
            r_cfg.height_curve <= '0;
            r_cfg.compensate   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LIGHT_X:      r_cfg.light_x      <= i_cfg_data[8:0];
                REG_LIGHT_Y:      r_cfg.light_y      <= i_cfg_data[8:0];
                REG_LIGHT_Z:      r_cfg.light_z      <= i_cfg_data[7:0];
                REG_NORMAL_Z:     r_cfg.normal_z     <= i_cfg_data[10:0];
                REG_COMPENSATION: r_cfg.compensation <= i_cfg_data[16:0];
                REG_AMBIENT:      r_cfg.ambient      <= i_cfg_data[7:0];
                REG_HEIGHT_CURVE: r_cfg.height_curve <= i_cfg_data[2:0];
                REG_COMPENSATE:   r_cfg.compensate   <= i_cfg_data[0];
                default:          r_cfg.compensate   <= r_cfg.compensate;
            endcase
        end
    end

    bms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_height      (s_axis_tdata),
        .i_row_end     (s_axis_tlast),
        .i_frame_start (s_axis_tuser),
        .i_room        (room),
        .o_push        (push),
        .o_grad        (push_grad)
    );

    bms_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_grad),
        .i_pop      (pop),
        .o_head     (head_grad),
        .o_nonempty (nonempty),
        .o_room     (room)
    );

    bms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_grad_valid (nonempty),
        .i_grad       (head_grad),
        .o_pop        (pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_shade      (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire
